FILE: design/pot_pkg.sv
// ----------------------------------------------------------------------------
// pot_pkg
// shared constants and types of the polygon overlap test
// ----------------------------------------------------------------------------
`default_nettype none
package pot_pkg;
    localparam int MaxVertices = 16;
    localparam int CoordWidth  = 16;
    localparam int IdxWidth    = $clog2(MaxVertices);
    localparam int CntWidth    = $clog2(MaxVertices + 1);
    localparam int QueueDepth  = 2;

    typedef logic signed [CoordWidth-1:0] t_coord;
    typedef logic [IdxWidth-1:0]          t_idx;
    typedef logic [CntWidth-1:0]          t_cnt;

    typedef struct packed {
        logic   action;
        t_coord vert_x;
        t_coord vert_y;
        logic   last_vertex;
    } t_in_word;

    typedef struct packed {
        logic   overlap;
    } t_out_word;

    // front to back: a store command or a test command
    typedef struct packed {
        logic   is_test;
        logic   poly;
        logic   store;
        t_idx   addr;
        t_coord x;
        t_coord y;
        t_cnt   n_first;
        t_cnt   n_second;
    } t_cmd;
endpackage
`default_nettype wire

FILE: design/pot_if.sv
// ----------------------------------------------------------------------------
// pot_in_if / pot_out_if
// valid/ready channels of the polygon overlap test
// ----------------------------------------------------------------------------
`default_nettype none
interface pot_in_if;
    logic              valid;
    logic              ready;
    pot_pkg::t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pot_out_if;
    logic               valid;
    logic               ready;
    pot_pkg::t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/polygon_overlap_test.sv
// ----------------------------------------------------------------------------
// polygon_overlap_test
// overlap test of two polygons by crossing-number ray casting
// ----------------------------------------------------------------------------
// A vertex word is taken whenever the queue has room. A test word (second
// polygon, last vertex) runs a sequencer over every point of each polygon
// against every edge of the other: each edge test steps through two reads, a
// multiply through one pair of 17x17 multipliers and a compare, and each point
// adds one read first. The test stops at the first inside point.
// Words queue in a two-entry queue while a test runs.
`default_nettype none
module polygon_overlap_test (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pot_in_if.sink    in_ch,
    pot_out_if.source out_ch
);
    import pot_pkg::*;

    t_cmd fcmd, qcmd;
    logic fvalid, fready, qvalid, qready;

    pot_front u_front (.i_clk, .i_rst_n, .in_ch, .o_cmd(fcmd),
                       .o_cmd_valid(fvalid), .i_cmd_ready(fready));
    pot_queue u_queue (.i_clk, .i_rst_n, .i_cmd(fcmd), .i_valid(fvalid),
                       .o_ready(fready), .o_cmd(qcmd), .o_valid(qvalid),
                       .i_ready(qready));
    pot_back  u_back  (.i_clk, .i_rst_n, .i_cmd(qcmd), .i_valid(qvalid),
                       .o_ready(qready), .out_ch);

    a_ready_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result lost");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> !qready) else $error("back took a word with result pending");
endmodule
`default_nettype wire

FILE: design/pot_front.sv
// ----------------------------------------------------------------------------
// pot_front
// accepts vertex words, keeps the counts and issues store and test commands
// ----------------------------------------------------------------------------
`default_nettype none
module pot_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    pot_in_if.sink             in_ch,
    output pot_pkg::t_cmd      o_cmd,
    output logic               o_cmd_valid,
    input  wire logic          i_cmd_ready
);
    import pot_pkg::*;

    t_cnt r_first_cnt, r_second_cnt;
    t_cnt n_first_cnt, n_second_cnt;
    logic fire;
    logic room;

    assign in_ch.ready = i_cmd_ready;
    assign o_cmd_valid = in_ch.valid;
    assign fire        = in_ch.valid && i_cmd_ready;

    always_comb begin
        room = in_ch.data.action ? (r_second_cnt < t_cnt'(MaxVertices))
                                 : (r_first_cnt < t_cnt'(MaxVertices));
        o_cmd.is_test = in_ch.data.action && in_ch.data.last_vertex;
        o_cmd.poly    = in_ch.data.action;
        o_cmd.store   = room;
        o_cmd.addr    = in_ch.data.action ? r_second_cnt[IdxWidth-1:0]
                                          : r_first_cnt[IdxWidth-1:0];
        o_cmd.x       = in_ch.data.vert_x;
        o_cmd.y       = in_ch.data.vert_y;
        o_cmd.n_first = r_first_cnt;
        o_cmd.n_second = (in_ch.data.action && room) ? r_second_cnt + t_cnt'(1)
                                                     : r_second_cnt;
        n_first_cnt  = r_first_cnt;
        n_second_cnt = r_second_cnt;
        if (fire) begin
            if (o_cmd.is_test) begin
                n_first_cnt  = '0;
                n_second_cnt = '0;
            end else if (room) begin
                if (in_ch.data.action) n_second_cnt = r_second_cnt + t_cnt'(1);
                else                   n_first_cnt  = r_first_cnt + t_cnt'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_cnt  <= '0;
            r_second_cnt <= '0;
        end else begin
            r_first_cnt  <= n_first_cnt;
            r_second_cnt <= n_second_cnt;
        end
    end
endmodule
`default_nettype wire

FILE: design/pot_queue.sv
// ----------------------------------------------------------------------------
// pot_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none
module pot_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  pot_pkg::t_cmd      i_cmd,
    input  wire logic          i_valid,
    output logic               o_ready,
    output pot_pkg::t_cmd      o_cmd,
    output logic               o_valid,
    input  wire logic          i_ready
);
    import pot_pkg::*;
    localparam int PtrW = $clog2(QueueDepth);

    t_cmd              r_mem [QueueDepth];
    logic [PtrW-1:0]   r_wp, r_rp;
    logic [PtrW:0]     r_cnt;
    logic              push, pop;

    assign o_ready = r_cnt < (PtrW+1)'(QueueDepth);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + PtrW'(1);
            if (pop)  r_rp <= r_rp + PtrW'(1);
            r_cnt <= r_cnt + (PtrW+1)'(push) - (PtrW+1)'(pop);
        end
    end
endmodule
`default_nettype wire

FILE: design/pot_back.sv
// ----------------------------------------------------------------------------
// pot_back
// vertex stores and the sequenced crossing-number test, one edge per step
// ----------------------------------------------------------------------------
`default_nettype none
module pot_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  pot_pkg::t_cmd      i_cmd,
    input  wire logic          i_valid,
    output logic               o_ready,
    pot_out_if.source          out_ch
);
    import pot_pkg::*;
    localparam int DW = CoordWidth + 1;
    localparam int PW = 2 * DW;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RDP  = 6'b000010,
        S_RDA  = 6'b000100,
        S_RDB  = 6'b001000,
        S_MUL  = 6'b010000,
        S_CMP  = 6'b100000
    } t_state;

    logic [2*CoordWidth-1:0] r_mem0 [MaxVertices];
    logic [2*CoordWidth-1:0] r_mem1 [MaxVertices];

    t_state r_st, n_st;
    logic   r_pass;                  // 0: first points vs second polygon
    t_cnt   r_nf, r_ns, r_pi, r_ei;
    logic   r_par, r_hit;
    logic   r_ovalid, r_oval;
    t_coord r_px, r_py, r_ax, r_ay;
    logic [2*CoordWidth-1:0] r_rd;
    logic signed [PW-1:0] r_p1, r_p2;
    logic   r_cnt_edge, r_dypos;

    t_cnt   npts, nedg, bi, pnext;
    t_idx   raddr;
    logic   rsel;
    t_coord bx, by;
    logic signed [DW-1:0] dy, dxp, dyp, dx;
    logic   take;

    assign o_ready      = (r_st == S_IDLE) && !r_ovalid;
    assign take         = i_valid && o_ready;
    assign out_ch.valid = r_ovalid;
    assign out_ch.data.overlap = r_oval;

    assign npts  = r_pass ? r_ns : r_nf;
    assign nedg  = r_pass ? r_nf : r_ns;
    assign bi    = (r_ei + t_cnt'(1) < nedg) ? r_ei + t_cnt'(1) : '0;
    assign pnext = r_pi + t_cnt'(1);
    assign bx    = t_coord'(r_rd[2*CoordWidth-1:CoordWidth]);
    assign by    = t_coord'(r_rd[CoordWidth-1:0]);
    assign dy    = DW'(by) - DW'(r_ay);
    assign dxp   = DW'(r_px) - DW'(r_ax);
    assign dyp   = DW'(r_py) - DW'(r_ay);
    assign dx    = DW'(bx) - DW'(r_ax);

    // next point / next pass selection
    function automatic logic [1:0] pick(input logic pass, input t_cnt pi,
                                        input t_cnt nf, input t_cnt ns);
        logic [1:0] r;
        r = 2'b00;
        // r[1]: done, r[0]: new pass
        if (!pass) begin
            if (pi + t_cnt'(1) < nf) r = 2'b00;
            else if (ns != '0)       r = 2'b01;
            else                     r = 2'b10;
        end else begin
            if (pi + t_cnt'(1) < ns) r = 2'b00;
            else                     r = 2'b10;
        end
        return r;
    endfunction

    logic [1:0] nx;
    assign nx = pick(r_pass, r_pi, r_nf, r_ns);

    // read address for the data needed in the next state, indexes still old
    always_comb begin
        rsel  = 1'b0;
        raddr = '0;
        case (n_st)
            S_RDP: begin
                if (r_st == S_CMP) begin
                    rsel  = r_pass | nx[0];
                    raddr = nx[0] ? '0 : pnext[IdxWidth-1:0];
                end else begin
                    rsel  = r_pass;
                    raddr = r_pi[IdxWidth-1:0];
                end
            end
            S_RDA: begin
                rsel  = !r_pass;
                raddr = (r_st == S_CMP) ? bi[IdxWidth-1:0] : r_ei[IdxWidth-1:0];
            end
            S_RDB:   begin rsel = !r_pass; raddr = bi[IdxWidth-1:0];   end
            S_MUL:   begin rsel = !r_pass; raddr = bi[IdxWidth-1:0];   end
            default: begin rsel = 1'b0;    raddr = '0;                 end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (take && i_cmd.store && !i_cmd.poly) r_mem0[i_cmd.addr] <= {i_cmd.x, i_cmd.y};
        if (take && i_cmd.store && i_cmd.poly)  r_mem1[i_cmd.addr] <= {i_cmd.x, i_cmd.y};
        r_rd <= rsel ? r_mem1[raddr] : r_mem0[raddr];
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: if (take && i_cmd.is_test) begin
                if (i_cmd.n_first != '0 && i_cmd.n_second != '0) n_st = S_RDP;
                else n_st = S_IDLE;
            end
            S_RDP:  n_st = S_RDA;
            S_RDA:  n_st = S_RDB;
            S_RDB:  n_st = S_MUL;
            S_MUL:  n_st = S_CMP;
            S_CMP: begin
                if (r_ei + t_cnt'(1) < nedg) n_st = S_RDA;
                else if ((r_par ^ (r_cnt_edge && (r_dypos ? r_p1 <= r_p2 : r_p1 <= r_p2)))
                         || nx[1]) n_st = S_IDLE;
                else n_st = S_RDP;
            end
            default: n_st = S_IDLE;
        endcase
    end

    logic hit_now, par_now;
    assign hit_now = r_cnt_edge && (r_p1 <= r_p2);
    assign par_now = r_par ^ hit_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (out_ch.valid && out_ch.ready) r_ovalid <= 1'b0;
            if (r_st == S_IDLE && take && i_cmd.is_test &&
                (i_cmd.n_first == '0 || i_cmd.n_second == '0)) begin
                r_ovalid <= 1'b1;
            end
            if (r_st == S_CMP && n_st == S_IDLE) r_ovalid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            S_IDLE: begin
                r_nf <= i_cmd.n_first;
                r_ns <= i_cmd.n_second;
                r_pass <= 1'b0;
                r_pi <= '0;
                r_ei <= '0;
                r_par <= 1'b0;
                // result word stays put until the next word is taken
                if (take) r_oval <= 1'b0;
            end
            S_RDP: begin r_px <= bx; r_py <= by; end
            S_RDA: begin r_ax <= bx; r_ay <= by; end
            S_RDB: ;
            S_MUL: begin
                r_cnt_edge <= (r_ay > r_py) != (by > r_py);
                r_dypos    <= dy > 0;
                // a*b <= c*d; for dy<=0 swap sides: dyp*dx <= dxp*dy
                if (dy > 0) begin
                    r_p1 <= PW'(dxp) * PW'(dy);
                    r_p2 <= PW'(dyp) * PW'(dx);
                end else begin
                    r_p1 <= PW'(dyp) * PW'(dx);
                    r_p2 <= PW'(dxp) * PW'(dy);
                end
            end
            S_CMP: begin
                if (r_ei + t_cnt'(1) < nedg) begin
                    r_ei  <= r_ei + t_cnt'(1);
                    r_par <= par_now;
                end else begin
                    r_ei  <= '0;
                    r_par <= 1'b0;
                    if (par_now) r_oval <= 1'b1;
                    else if (nx[0]) begin r_pass <= 1'b1; r_pi <= '0; end
                    else r_pi <= r_pi + t_cnt'(1);
                end
            end
            default: ;
        endcase
    end

    logic unused;
    assign unused = r_hit ^ r_dypos ^ (npts == '0);
    always_ff @(posedge i_clk) r_hit <= unused;
endmodule
`default_nettype wire
